### rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned HeapBytes   = 4096;
  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned Align       = 8;
  localparam int unsigned Depth       = HeapBytes / Align;
  localparam int unsigned AddrW       = $clog2(Depth);
  localparam int unsigned LenW        = 13;
  localparam int unsigned EntryW      = LenW + 1;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoMem   = 2'd1;
  localparam logic [1:0] StIgnored = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_F_RD,
    S_F_CHK,
    S_M_RD,
    S_M_CHK,
    S_M_NRD,
    S_M_NCHK,
    S_T_RD,
    S_T_CHK,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] granted_offset;
    logic [12:0] free_total;
    logic [12:0] largest_free;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [EntryW-1:0] wdata;
    logic [AddrW-1:0]  raddr;
  } mem_req_t;

endpackage

### rtl/ffha_if.sv
// ----------------------------------------------------------------------------
// ffha_req_if / ffha_rsp_if
// Valid/ready channels for request and result items.
// ----------------------------------------------------------------------------
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] request_bytes;
  logic [11:0] payload_offset;
  modport source (output valid, mode, request_bytes, payload_offset, input ready);
  modport sink   (input valid, mode, request_bytes, payload_offset, output ready);
endinterface

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] granted_offset;
  logic [12:0] free_total;
  logic [12:0] largest_free;
  modport source (output valid, status, granted_offset, free_total, largest_free,
                  input ready);
  modport sink   (input valid, status, granted_offset, free_total, largest_free,
                  output ready);
endinterface

### rtl/ffha_hdr_mem.sv
// ----------------------------------------------------------------------------
// ffha_hdr_mem
// Header store: one entry per 8-byte slot, registered read, one write port.
// ----------------------------------------------------------------------------
module ffha_hdr_mem (
  input  logic                       clk_i,
  input  ffha_pkg::mem_req_t         req_i,
  output logic [ffha_pkg::EntryW-1:0] rdata_o
);

  logic [ffha_pkg::EntryW-1:0] mem_q [ffha_pkg::Depth];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

### rtl/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Header walk sequencer: allocate, free lookup, merge pass and statistics.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        mode_i,
  input  logic [15:0]                 req_i,
  input  logic [11:0]                 off_i,
  input  logic                        out_free_i,
  output logic                        busy_o,
  output logic                        done_o,
  output ffha_pkg::result_t           res_o,
  output ffha_pkg::mem_req_t          mem_o,
  input  logic [ffha_pkg::EntryW-1:0] rdata_i
);
  localparam int unsigned PW = $clog2(ffha_pkg::HeapBytes) + 1;
  localparam int unsigned HB = ffha_pkg::HeapBytes;
  localparam int unsigned HD = ffha_pkg::HeaderBytes;
  localparam int unsigned AS = $clog2(ffha_pkg::Align);

  ffha_pkg::state_e state_q, state_d;
  logic [PW-1:0]  pos_q, pos_d, nxt_q, nxt_d;
  logic [16:0]    need_q, need_d;
  logic [PW-1:0]  tgt_q, tgt_d;
  logic [12:0]    len_q, len_d;
  logic [1:0]     st_q, st_d;
  logic [11:0]    gr_q, gr_d;
  logic [12:0]    tot_q, tot_d, big_q, big_d;
  logic           init_q;
  ffha_pkg::result_t res_q, res_d;

  logic [12:0]    rlen;
  logic           rfree;
  logic [PW-1:0]  rnext;
  logic [17:0]    tailp;
  logic [17:0]    sum3;
  logic           fit;
  logic           split;

  ffha_pkg::mem_req_t          mem_c;
  logic                        tpend_q;
  logic [ffha_pkg::AddrW-1:0]  taddr_q;
  logic [ffha_pkg::EntryW-1:0] tdata_q;

  assign rlen  = init_q ? 13'(HB - HD) : rdata_i[ffha_pkg::EntryW-1:1];
  assign rfree = init_q ? 1'b1 : rdata_i[0];
  assign rnext = pos_q + PW'(HD) + PW'(rlen);
  assign tailp = 18'(pos_q) + 18'(HD) + 18'(need_q);
  assign sum3  = 18'(len_q) + 18'(HD) + 18'(rlen);
  assign fit   = rfree && 17'(rlen) >= need_q;
  assign split = (18'(rlen) > 18'(need_q) + 18'(HD + 8)) && (tailp < 18'(HB));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ffha_pkg::S_IDLE: if (start_i) begin
        if (mode_i) begin
          state_d = (off_i < 12'(HD)) ? ffha_pkg::S_T_RD : ffha_pkg::S_F_RD;
        end else begin
          state_d = (req_i > 16'(HB)) ? ffha_pkg::S_T_RD : ffha_pkg::S_A_RD;
        end
      end
      ffha_pkg::S_A_RD:  state_d = ffha_pkg::S_A_CHK;
      ffha_pkg::S_A_CHK: begin
        if (fit) state_d = ffha_pkg::S_T_RD;
        else if (rnext >= PW'(HB)) state_d = ffha_pkg::S_T_RD;
        else state_d = ffha_pkg::S_A_RD;
      end
      ffha_pkg::S_F_RD:  state_d = ffha_pkg::S_F_CHK;
      ffha_pkg::S_F_CHK: begin
        if (pos_q == tgt_q) state_d = ffha_pkg::S_M_RD;
        else if (pos_q > tgt_q || rnext >= PW'(HB)) state_d = ffha_pkg::S_T_RD;
        else state_d = ffha_pkg::S_F_RD;
      end
      ffha_pkg::S_M_RD:  state_d = ffha_pkg::S_M_CHK;
      ffha_pkg::S_M_CHK: begin
        if (rnext >= PW'(HB)) state_d = ffha_pkg::S_T_RD;
        else if (rfree) state_d = ffha_pkg::S_M_NRD;
        else state_d = ffha_pkg::S_M_RD;
      end
      ffha_pkg::S_M_NRD:  state_d = ffha_pkg::S_M_NCHK;
      ffha_pkg::S_M_NCHK: state_d = ffha_pkg::S_M_RD;
      ffha_pkg::S_T_RD:  state_d = ffha_pkg::S_T_CHK;
      ffha_pkg::S_T_CHK: if (rnext >= PW'(HB)) state_d = ffha_pkg::S_OUT;
                         else state_d = ffha_pkg::S_T_RD;
      ffha_pkg::S_OUT: if (out_free_i) state_d = ffha_pkg::S_IDLE;
      default: state_d = ffha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pos_d = pos_q; nxt_d = nxt_q; need_d = need_q; tgt_d = tgt_q; len_d = len_q;
    st_d = st_q; gr_d = gr_q; tot_d = tot_q; big_d = big_q; res_d = res_q;
    mem_c = '0;
    mem_c.raddr = ffha_pkg::AddrW'(pos_q >> AS);
    unique case (state_q)
      ffha_pkg::S_IDLE: if (start_i) begin
        pos_d = '0; gr_d = '0; tot_d = '0; big_d = '0;
        need_d = (17'(req_i) + 17'd7) & ~17'd7;
        tgt_d  = PW'(off_i) - PW'(HD);
        st_d   = mode_i ? ffha_pkg::StIgnored : ffha_pkg::StNoMem;
      end
      ffha_pkg::S_A_CHK: begin
        if (fit) begin
          st_d = ffha_pkg::StOk;
          gr_d = 12'(pos_q + PW'(HD));
          mem_c.we = 1'b1;
          mem_c.waddr = ffha_pkg::AddrW'(pos_q >> AS);
          mem_c.wdata = {split ? 13'(need_q) : rlen, 1'b0};
          pos_d = '0;
        end else if (rnext >= PW'(HB)) begin
          pos_d = '0;
        end else begin
          pos_d = rnext;
        end
      end
      ffha_pkg::S_F_CHK: begin
        if (pos_q == tgt_q) begin
          st_d = ffha_pkg::StOk;
          mem_c.we = 1'b1;
          mem_c.waddr = ffha_pkg::AddrW'(pos_q >> AS);
          mem_c.wdata = {rlen, 1'b1};
          pos_d = '0;
        end else if (pos_q > tgt_q || rnext >= PW'(HB)) begin
          pos_d = '0;
        end else begin
          pos_d = rnext;
        end
      end
      ffha_pkg::S_M_CHK: begin
        len_d = rlen;
        if (rnext >= PW'(HB)) pos_d = '0;
        else if (rfree) nxt_d = rnext;
        else pos_d = rnext;
      end
      ffha_pkg::S_M_NRD: mem_c.raddr = ffha_pkg::AddrW'(nxt_q >> AS);
      ffha_pkg::S_M_NCHK: begin
        if (rfree) begin
          mem_c.we = 1'b1;
          mem_c.waddr = ffha_pkg::AddrW'(pos_q >> AS);
          mem_c.wdata = {13'(sum3), 1'b1};
        end else begin
          pos_d = nxt_q;
        end
      end
      ffha_pkg::S_T_CHK: begin
        if (rfree) begin
          tot_d = tot_q + rlen;
          if (rlen > big_q) big_d = rlen;
        end
        pos_d = rnext;
        if (rnext >= PW'(HB)) begin
          res_d.status = st_q;
          res_d.granted_offset = gr_q;
          res_d.free_total = rfree ? tot_q + rlen : tot_q;
          res_d.largest_free = (rfree && rlen > big_q) ? rlen : big_q;
        end
      end
      default: ;
    endcase
  end

  // split tail header goes out on the cycle after the used header
  always_comb begin
    mem_o = mem_c;
    if (tpend_q) begin
      mem_o.we = 1'b1;
      mem_o.waddr = taddr_q;
      mem_o.wdata = tdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffha_pkg::S_IDLE;
      init_q  <= 1'b1;
      tpend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_o.we && mem_o.waddr == '0) init_q <= 1'b0;
      tpend_q <= (state_q == ffha_pkg::S_A_CHK) && fit && split;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d; nxt_q <= nxt_d; need_q <= need_d; tgt_q <= tgt_d;
    len_q <= len_d; st_q <= st_d; gr_q <= gr_d; tot_q <= tot_d; big_q <= big_d;
    res_q <= res_d;
    if (state_q == ffha_pkg::S_A_CHK) begin
      taddr_q <= ffha_pkg::AddrW'(tailp >> AS);
      tdata_q <= {13'(18'(rlen) - 18'(need_q) - 18'(HD)), 1'b1};
    end
  end

  assign busy_o  = (state_q != ffha_pkg::S_IDLE);
  assign done_o  = (state_q == ffha_pkg::S_OUT);
  assign res_o   = res_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffha_pkg::S_OUT) |-> (res_q.free_total >= res_q.largest_free))
    else $error("largest exceeds total");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffha_pkg::S_OUT && res_q.status == ffha_pkg::StNoMem)
      |-> (res_q.granted_offset == '0))
    else $error("grant on failure");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tpend_q |-> $past(state_q == ffha_pkg::S_A_CHK))
    else $error("stray header write");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tpend_q |-> !mem_c.we)
    else $error("header write collision");
endmodule

### rtl/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator with split and coalesce over a header memory.
// ----------------------------------------------------------------------------
// channel   dir  fields
// req_if    in   mode, request_bytes, payload_offset
// rsp_if    out  status, granted_offset, free_total, largest_free
//
// One item at a time; each header visit is a read then a check on the
// single-port-read header memory; a merge adds a read and a check of the next header.
// Allocate: search plus statistics pass.
// Free: lookup, merge pass and statistics pass.
// Reset is immediate: block 0 reads as the whole heap until first written.
// A result waits in its register until taken; no new item enters meanwhile.
module first_fit_heap_allocator (
  input  logic         clk_i,
  input  logic         rst_ni,
  ffha_req_if.sink     req_if,
  ffha_rsp_if.source   rsp_if
);
  logic busy, done;
  ffha_pkg::result_t res;
  ffha_pkg::mem_req_t mreq;
  logic [ffha_pkg::EntryW-1:0] rdata;

  assign req_if.ready = !busy;

  ffha_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i    (req_if.valid && !busy),
    .mode_i     (req_if.mode),
    .req_i      (req_if.request_bytes),
    .off_i      (req_if.payload_offset),
    .out_free_i (rsp_if.ready),
    .busy_o     (busy),
    .done_o     (done),
    .res_o      (res),
    .mem_o      (mreq),
    .rdata_i    (rdata)
  );

  ffha_hdr_mem u_mem (.clk_i, .req_i(mreq), .rdata_o(rdata));

  assign rsp_if.valid          = done;
  assign rsp_if.status         = res.status;
  assign rsp_if.granted_offset = res.granted_offset;
  assign rsp_if.free_total     = res.free_total;
  assign rsp_if.largest_free   = res.largest_free;
endmodule

### tb/ffha_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_checker
// Watches the request and result channels of the heap allocator, tracks a
// block-list image of the heap, predicts each result and compares it.
// ----------------------------------------------------------------------------
module ffha_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  logic              req_mode_i,
  input  logic [15:0]       req_bytes_i,
  input  logic [11:0]       req_offset_i,
  input  logic              rsp_valid_i,
  input  logic              rsp_ready_i,
  input  ffha_pkg::result_t rsp_i,
  output int                errors_o,
  output int                pending_o
);

  int unsigned       blk_size [ffha_pkg::HeapBytes];
  bit                blk_free [ffha_pkg::HeapBytes];
  ffha_pkg::result_t expected_results [$];
  int                errors;
  int                pending;

  assign errors_o  = errors;
  assign pending_o = pending;

  function automatic ffha_pkg::result_t heap_apply(bit mode, int unsigned req,
                                                   int unsigned off);
    ffha_pkg::result_t r;
    int unsigned need, pos, len, tail, target, nxt, total, largest;
    bit          found;
    r = '0;
    pos = 0;
    target = 0;
    if (!mode) begin
      need = (req + 7) & ~32'd7;
      r.status = ffha_pkg::StNoMem;
      while (pos < ffha_pkg::HeapBytes) begin
        len = blk_size[pos];
        if (blk_free[pos] && len >= need) begin
          tail = pos + ffha_pkg::HeaderBytes + need;
          if (len > need + ffha_pkg::HeaderBytes + 8 && tail < ffha_pkg::HeapBytes) begin
            blk_size[tail] = len - need - ffha_pkg::HeaderBytes;
            blk_free[tail] = 1'b1;
            blk_size[pos] = need;
          end
          blk_free[pos] = 1'b0;
          r.status = ffha_pkg::StOk;
          r.granted_offset = 12'(pos + ffha_pkg::HeaderBytes);
          break;
        end
        pos += ffha_pkg::HeaderBytes + len;
      end
    end else begin
      r.status = ffha_pkg::StIgnored;
      found = 1'b0;
      if (off >= ffha_pkg::HeaderBytes) begin
        target = off - ffha_pkg::HeaderBytes;
        while (pos < ffha_pkg::HeapBytes && pos <= target) begin
          if (pos == target) begin
            found = 1'b1;
            break;
          end
          pos += ffha_pkg::HeaderBytes + blk_size[pos];
        end
      end
      if (found) begin
        r.status = ffha_pkg::StOk;
        blk_free[target] = 1'b1;
        pos = 0;
        while (pos < ffha_pkg::HeapBytes) begin
          nxt = pos + ffha_pkg::HeaderBytes + blk_size[pos];
          if (nxt >= ffha_pkg::HeapBytes) break;
          if (blk_free[pos] && blk_free[nxt])
            blk_size[pos] = blk_size[pos] + ffha_pkg::HeaderBytes + blk_size[nxt];
          else
            pos = nxt;
        end
      end
    end
    total = 0;
    largest = 0;
    pos = 0;
    while (pos < ffha_pkg::HeapBytes) begin
      if (blk_free[pos]) begin
        total += blk_size[pos];
        if (blk_size[pos] > largest) largest = blk_size[pos];
      end
      pos += ffha_pkg::HeaderBytes + blk_size[pos];
    end
    r.free_total = 13'(total);
    r.largest_free = 13'(largest);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ffha_pkg::result_t exp_r;
    if (!rst_ni) begin
      errors <= 0;
      pending <= 0;
      expected_results.delete();
      foreach (blk_size[i]) begin
        blk_size[i] = 0;
        blk_free[i] = 1'b0;
      end
      blk_size[0] = ffha_pkg::HeapBytes - ffha_pkg::HeaderBytes;
      blk_free[0] = 1'b1;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, rsp_i);
          errors <= errors + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (rsp_i !== exp_r) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, rsp_i);
            errors <= errors + 1;
          end
        end
      end
      if (req_valid_i && req_ready_i)
        expected_results.push_back(heap_apply(req_mode_i, req_bytes_i, req_offset_i));
      pending <= expected_results.size();
    end
  end

endmodule

### tb/first_fit_heap_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Directed and random allocate/free traffic under varying handshake idling;
// results are checked by ffha_checker.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;

  localparam int MaxCycles = 20_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending;
  int   cycles = 0;
  int   idle_pct, stall_pct;
  logic [11:0] live_blocks [$];

  ffha_req_if req_if ();
  ffha_rsp_if rsp_if ();

  first_fit_heap_allocator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_if),
    .rsp_if (rsp_if)
  );

  ffha_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_if.valid),
    .req_ready_i  (req_if.ready),
    .req_mode_i   (req_if.mode),
    .req_bytes_i  (req_if.request_bytes),
    .req_offset_i (req_if.payload_offset),
    .rsp_valid_i  (rsp_if.valid),
    .rsp_ready_i  (rsp_if.ready),
    .rsp_i        ({rsp_if.status, rsp_if.granted_offset, rsp_if.free_total,
                    rsp_if.largest_free}),
    .errors_o     (errors),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) rsp_if.ready <= ($urandom_range(99) >= stall_pct);

  // Track granted offsets from results so frees target real blocks.
  always @(posedge clk_i)
    if (rsp_if.valid && rsp_if.ready && rsp_if.status == ffha_pkg::StOk &&
        rsp_if.granted_offset != 0)
      live_blocks.push_back(rsp_if.granted_offset);

  task automatic send(bit mode, logic [15:0] nbytes, logic [11:0] off);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.mode <= mode;
    req_if.request_bytes <= nbytes;
    req_if.payload_offset <= off;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic random_item();
    int          k, sel;
    logic [11:0] off;
    sel = $urandom_range(99);
    if (sel < 45) send(1'b0, 16'($urandom_range(sel < 5 ? 65535 : 300)), 12'($urandom));
    else if (sel < 85 && live_blocks.size() > 0) begin
      k = $urandom_range(live_blocks.size() - 1);
      off = live_blocks[k];
      live_blocks.delete(k);
      send(1'b1, 16'($urandom), off);
    end else if (sel < 92) send(1'b1, 16'($urandom), 12'($urandom));
    else send(1'b1, 16'($urandom), 12'($urandom_range(7)));
  endtask

  initial begin
    idle_pct = 0;
    stall_pct = 0;
    req_if.valid = 1'b0;
    req_if.mode = 1'b0;
    req_if.request_bytes = '0;
    req_if.payload_offset = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send(1'b0, 16'd0, 12'd0);
    send(1'b0, 16'd1, 12'hfff);
    send(1'b0, 16'd24, 12'd0);
    send(1'b1, 16'hffff, 12'd0);
    send(1'b1, 16'd0, 12'd4);
    send(1'b1, 16'd0, 12'd12);
    send(1'b1, 16'd0, 12'd24);
    send(1'b1, 16'd0, 12'd24);
    send(1'b0, 16'hffff, 12'd0);
    send(1'b0, 16'd4096, 12'd0);
    send(1'b1, 16'd0, 12'd8);
    send(1'b1, 16'd0, 12'd16);
    send(1'b1, 16'd0, 12'hfff);
    send(1'b0, 16'd4088, 12'd0);
    send(1'b0, 16'd8, 12'd0);
    send(1'b1, 16'd0, 12'd8);
    send(1'b0, 16'd4072, 12'd0);
    send(1'b1, 16'd0, 12'd8);
    send(1'b0, 16'h5555, 12'haaa);
    send(1'b1, 16'haaaa, 12'h555);
    req_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    @(negedge clk_i);
    live_blocks.delete();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = (ph == 1) ? 56 : (ph == 3) ? 23 : 0;
      stall_pct = (ph == 2) ? 56 : (ph == 3) ? 23 : 0;
      for (int i = 0; i < 185; i++) random_item();
    end
    req_if.valid <= 1'b0;
    stall_pct = 0;

    while (pending != 0) @(posedge clk_i);
    repeat (4000) @(posedge clk_i);
    if (errors == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
